[rtl/core/pwfp_pkg.sv]
// ----------------------------------------------------------------------------
// pwfp_pkg: shared types and constants of the wire-format field parser
// Parse phases, event and error codes, and the items passed between the
// front queue, the parser and the result queue.
// ----------------------------------------------------------------------------
package pwfp_pkg;

   typedef enum logic [4:0] {
      PH_KEY     = 5'b00001,
      PH_VALUE   = 5'b00010,
      PH_LENGTH  = 5'b00100,
      PH_PAYLOAD = 5'b01000,
      PH_DISCARD = 5'b10000
   } phase_type;

   typedef enum logic [1:0] {
      EV_KEY     = 2'd0,
      EV_VARINT  = 2'd1,
      EV_LENGTH  = 2'd2,
      EV_PAYLOAD = 2'd3
   } event_type;

   typedef enum logic [2:0] {
      ERR_NONE       = 3'd0,
      ERR_TRUNCATED  = 3'd1,
      ERR_TOO_LONG   = 3'd2,
      ERR_FIELD_ZERO = 3'd3,
      ERR_WIRE_TYPE  = 3'd4
   } error_type;

   localparam logic [2:0] WIRE_VARINT = 3'd0;
   localparam logic [2:0] WIRE_LENGTH = 3'd2;

   // index of the tenth varint byte
   localparam logic [3:0] LAST_VARINT_BYTE = 4'd9;

   typedef struct packed {
      logic       cont;
      logic [6:0] bits;
      logic       last;
   } byte_item_type;

   typedef struct packed {
      event_type   kind;
      logic [31:0] field_number;
      logic [2:0]  wire_code;
      logic [63:0] value;
      logic        payload_last;
      logic        message_end;
      error_type   error;
   } result_type;

endpackage

[rtl/core/pwfp_fifo.sv]
// ----------------------------------------------------------------------------
// pwfp_fifo: small synchronous queue
// Register-based first-in first-out store with full and empty flags.
// ----------------------------------------------------------------------------
module pwfp_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wr_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] rd_data,
   output logic             empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rd_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({do_push, do_pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

[rtl/core/pwfp_front.sv]
// ----------------------------------------------------------------------------
// pwfp_front: request intake
// Splits each request byte into continuation flag and data bits and queues
// it for the parser.
// ----------------------------------------------------------------------------
module pwfp_front
   import pwfp_pkg::*;
#(
   parameter int DEPTH = 4
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   input  logic [7:0]    data_byte,
   input  logic          message_last,
   output logic          full,
   input  logic          head_pop,
   output byte_item_type head,
   output logic          head_valid
);

   byte_item_type item;
   logic          head_empty;

   always_comb begin
      item.cont = data_byte[7];
      item.bits = data_byte[6:0];
      item.last = message_last;
   end

   pwfp_fifo #(
      .WIDTH ($bits(byte_item_type)),
      .DEPTH (DEPTH)
   ) u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .wr_data (item),
      .full    (full),
      .pop     (head_pop),
      .rd_data (head),
      .empty   (head_empty)
   );

   assign head_valid = !head_empty;

endmodule

[rtl/core/pwfp_back.sv]
// ----------------------------------------------------------------------------
// pwfp_back: field parser and result queue
// Runs the key / value / length / payload / discard state machine on one queued
// byte per cycle while the result queue has room, and queues the results it produces.
// ----------------------------------------------------------------------------
module pwfp_back
   import pwfp_pkg::*;
#(
   parameter int DEPTH = 4
) (
   input  logic          clock,
   input  logic          reset,
   input  byte_item_type head,
   input  logic          head_valid,
   output logic          head_pop,
   output result_type    rsp,
   output logic          rsp_empty,
   input  logic          rsp_pop
);

   phase_type   phase_ff, phase_in;
   logic [63:0] acc_ff, acc_in;
   logic [3:0]  shift_ff, shift_in;
   logic [31:0] field_ff, field_in;
   logic [2:0]  wire_ff, wire_in;
   logic [63:0] remain_ff, remain_in;

   result_type  res;
   logic        res_valid;
   logic        res_full;
   logic        go;
   logic        fail;
   logic [3:0]  pos;
   logic [63:0] acc_new;
   logic [63:0] remain_dec;
   logic [31:0] key_field;
   logic [2:0]  key_wire;

   function automatic logic [63:0] place_bits(input logic [6:0] bits,
                                              input logic [3:0] at);
      logic [63:0] wide;
      wide = {57'd0, bits};
      case (at)
         4'd0:    return wide;
         4'd1:    return wide << 7;
         4'd2:    return wide << 14;
         4'd3:    return wide << 21;
         4'd4:    return wide << 28;
         4'd5:    return wide << 35;
         4'd6:    return wide << 42;
         4'd7:    return wide << 49;
         4'd8:    return wide << 56;
         default: return wide << 63;
      endcase
   endfunction

   // advance only when a byte is waiting and the result queue has room
   assign go       = head_valid && !res_full;
   assign head_pop = go;

   assign pos        = (shift_ff > LAST_VARINT_BYTE) ? LAST_VARINT_BYTE : shift_ff;
   assign acc_new    = acc_ff | place_bits(head.bits, pos);
   assign remain_dec = (remain_ff == '0) ? '0 : remain_ff - 1'b1;
   assign key_field  = acc_new[34:3];
   assign key_wire   = acc_new[2:0];

   always_comb begin
      phase_in  = phase_ff;
      acc_in    = acc_ff;
      shift_in  = shift_ff;
      field_in  = field_ff;
      wire_in   = wire_ff;
      remain_in = remain_ff;
      res_valid = 1'b0;
      fail      = 1'b0;

      res.kind         = EV_KEY;
      res.field_number = field_ff;
      res.wire_code    = wire_ff;
      res.value        = '0;
      res.payload_last = 1'b0;
      res.message_end  = head.last;
      res.error        = ERR_NONE;

      case (phase_ff)
         PH_PAYLOAD: begin
            res.kind  = EV_PAYLOAD;
            res.value = {56'd0, head.cont, head.bits};
            remain_in = remain_dec;
            if (remain_dec == '0) begin
               res_valid        = 1'b1;
               res.payload_last = 1'b1;
               phase_in         = PH_KEY;
            end else if (head.last) begin
               fail      = 1'b1;
               res.error = ERR_TRUNCATED;
            end else begin
               res_valid = 1'b1;
            end
         end
         PH_DISCARD: begin
            if (head.last) begin
               phase_in = PH_KEY;
            end
         end
         PH_KEY, PH_VALUE, PH_LENGTH: begin
            case (phase_ff)
               PH_VALUE:  res.kind = EV_VARINT;
               PH_LENGTH: res.kind = EV_LENGTH;
               default:   res.kind = EV_KEY;
            endcase
            if (head.cont) begin
               if (pos == LAST_VARINT_BYTE) begin
                  fail      = 1'b1;
                  res.error = ERR_TOO_LONG;
               end else if (head.last) begin
                  fail      = 1'b1;
                  res.error = ERR_TRUNCATED;
               end else begin
                  acc_in   = acc_new;
                  shift_in = pos + 1'b1;
               end
               if (phase_ff == PH_KEY) begin
                  res.field_number = '0;
                  res.wire_code    = '0;
               end else begin
                  res.value = acc_new;
               end
            end else begin
               acc_in   = '0;
               shift_in = '0;
               if (phase_ff == PH_KEY) begin
                  field_in         = key_field;
                  wire_in          = key_wire;
                  res.field_number = key_field;
                  res.wire_code    = key_wire;
                  if (key_field == '0) begin
                     fail      = 1'b1;
                     res.error = ERR_FIELD_ZERO;
                  end else if (key_wire != WIRE_VARINT && key_wire != WIRE_LENGTH) begin
                     fail      = 1'b1;
                     res.error = ERR_WIRE_TYPE;
                  end else if (head.last) begin
                     fail      = 1'b1;
                     res.error = ERR_TRUNCATED;
                  end else begin
                     res_valid       = 1'b1;
                     res.message_end = 1'b0;
                     phase_in        = (key_wire == WIRE_VARINT) ? PH_VALUE : PH_LENGTH;
                  end
               end else if (phase_ff == PH_VALUE) begin
                  res_valid = 1'b1;
                  res.value = acc_new;
                  phase_in  = PH_KEY;
               end else if (acc_new == '0) begin
                  res_valid = 1'b1;
                  phase_in  = PH_KEY;
               end else if (head.last) begin
                  fail      = 1'b1;
                  res.error = ERR_TRUNCATED;
                  res.value = acc_new;
               end else begin
                  res_valid       = 1'b1;
                  res.value       = acc_new;
                  res.message_end = 1'b0;
                  remain_in       = acc_new;
                  phase_in        = PH_PAYLOAD;
               end
            end
         end
         default: begin
            phase_in = PH_KEY;
         end
      endcase

      // an error drops the field and skips to the end of the message
      if (fail) begin
         res_valid        = 1'b1;
         res.payload_last = 1'b0;
         res.message_end  = head.last;
         acc_in           = '0;
         shift_in         = '0;
         remain_in        = '0;
         phase_in         = head.last ? PH_KEY : PH_DISCARD;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_KEY;
         acc_ff    <= '0;
         shift_ff  <= '0;
         field_ff  <= '0;
         wire_ff   <= '0;
         remain_ff <= '0;
      end else if (go) begin
         phase_ff  <= phase_in;
         acc_ff    <= acc_in;
         shift_ff  <= shift_in;
         field_ff  <= field_in;
         wire_ff   <= wire_in;
         remain_ff <= remain_in;
      end
   end

   pwfp_fifo #(
      .WIDTH ($bits(result_type)),
      .DEPTH (DEPTH)
   ) u_results (
      .clock   (clock),
      .reset   (reset),
      .push    (go && res_valid),
      .wr_data (res),
      .full    (res_full),
      .pop     (rsp_pop),
      .rd_data (rsp),
      .empty   (rsp_empty)
   );

endmodule

[rtl/core/protobuf_wire_field_parser.sv]
// ----------------------------------------------------------------------------
// protobuf_wire_field_parser: streaming wire-format field decoder
// Turns a stream of message bytes into key, value, length and payload events.
// ----------------------------------------------------------------------------
// Request channel: write one message byte per request with push while full
// is low; req_message_last marks the last byte of a message.
// Result channel: while empty is low the oldest result sits on the rsp_
// ports; pop takes it. A byte gives zero or one result (continuation bytes
// of a varint give none unless they fail, and dropped bytes give none).
// Path: a taken byte waits in the request queue; the parser steps the head
// byte combinationally and writes its result into the result queue at the
// edge that pops the byte, after which the result sits on the rsp_ ports.
// Throughput: one byte per cycle, as each byte is parsed combinationally; the
// parser stalls only when the result queue is full, and the request queue
// keeps taking bytes until it fills in turn.
// Errors are reported once, then bytes are dropped up to the message end.
// Reset: both queues empty, the parser waits for a key; no clearing pass.
// ----------------------------------------------------------------------------
module protobuf_wire_field_parser
   import pwfp_pkg::*;
#(
   parameter int IN_DEPTH  = 4,
   parameter int OUT_DEPTH = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   output logic        full,
   input  logic [7:0]  req_data_byte,
   input  logic        req_message_last,
   output logic        empty,
   input  logic        pop,
   output logic [1:0]  rsp_event_kind,
   output logic [31:0] rsp_field_number,
   output logic [2:0]  rsp_wire_type,
   output logic [63:0] rsp_field_value,
   output logic        rsp_payload_last,
   output logic        rsp_message_end,
   output logic [2:0]  rsp_error_code
);

   byte_item_type head;
   logic          head_valid;
   logic          head_pop;
   result_type    rsp;

   pwfp_front #(
      .DEPTH (IN_DEPTH)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .push         (push),
      .data_byte    (req_data_byte),
      .message_last (req_message_last),
      .full         (full),
      .head_pop     (head_pop),
      .head         (head),
      .head_valid   (head_valid)
   );

   pwfp_back #(
      .DEPTH (OUT_DEPTH)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .head_valid (head_valid),
      .head_pop   (head_pop),
      .rsp        (rsp),
      .rsp_empty  (empty),
      .rsp_pop    (pop)
   );

   assign rsp_event_kind   = rsp.kind;
   assign rsp_field_number = rsp.field_number;
   assign rsp_wire_type    = rsp.wire_code;
   assign rsp_field_value  = rsp.value;
   assign rsp_payload_last = rsp.payload_last;
   assign rsp_message_end  = rsp.message_end;
   assign rsp_error_code   = rsp.error;

endmodule

[rtl/core/pwfp_checker.sv]
// ----------------------------------------------------------------------------
// pwfp_checker: port-level checks of the field parser
// Watches the request and result ports over time and reports violations.
// ----------------------------------------------------------------------------
module pwfp_checker
   import pwfp_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        full,
   input logic        empty,
   input logic        pop,
   input logic [1:0]  rsp_event_kind,
   input logic [31:0] rsp_field_number,
   input logic [2:0]  rsp_wire_type,
   input logic [63:0] rsp_field_value,
   input logic        rsp_payload_last,
   input logic        rsp_message_end,
   input logic [2:0]  rsp_error_code
);

   // both queues come out of reset empty
   a_reset_empty: assert property (@(posedge clock)
      reset |=> empty && !full)
      else $error("queues not empty after reset");

   // hold a waiting result until it is taken
   a_result_held: assert property (@(posedge clock) disable iff (reset)
      !empty && !pop |=> !empty && $stable(rsp_field_value))
      else $error("waiting result lost or changed");

   a_payload_last: assert property (@(posedge clock) disable iff (reset)
      !empty && rsp_payload_last |->
         rsp_event_kind == EV_PAYLOAD && rsp_error_code == ERR_NONE)
      else $error("payload end marked on a non-payload or error result");

   // a good key never closes a message, never names field zero and has a varint or length wire type
   a_good_key: assert property (@(posedge clock) disable iff (reset)
      !empty && rsp_event_kind == EV_KEY && rsp_error_code == ERR_NONE |->
         !rsp_message_end && rsp_field_number != '0 &&
         (rsp_wire_type == WIRE_VARINT || rsp_wire_type == WIRE_LENGTH))
      else $error("accepted key is malformed");

   a_error_range: assert property (@(posedge clock) disable iff (reset)
      !empty |-> rsp_error_code <= ERR_WIRE_TYPE)
      else $error("error code out of range");

endmodule

bind protobuf_wire_field_parser pwfp_checker u_pwfp_checker (.*);
